### rtl/kle_pkg.sv
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types and constants of the keystroke line editor.
// ----------------------------------------------------------------------------
package kle_pkg;

  localparam int CHAR_W = 8;
  localparam int CMD_W  = 3;

  // Keystroke command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_BACKSPACE = 3'd1,
    CMD_LEFT      = 3'd2,
    CMD_RIGHT     = 3'd3,
    CMD_EOL       = 3'd4
  } kle_cmd_t;

  // Shift controls broadcast to every cell of the chain
  typedef struct packed {
    logic left_push;
    logic left_pop;
    logic right_push;
    logic right_pop;
  } kle_shift_t;

endpackage

### rtl/kle_key_if.sv
// ----------------------------------------------------------------------------
// kle_key_if
// Keystroke channel: valid/ready handshake with command and character.
// ----------------------------------------------------------------------------
interface kle_key_if;
  import kle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] key_char;

  modport source (output valid, output cmd, output key_char, input ready);
  modport sink   (input valid, input cmd, input key_char, output ready);

endinterface

### rtl/kle_char_if.sv
// ----------------------------------------------------------------------------
// kle_char_if
// Line output channel: one character of the edited line per transaction.
// ----------------------------------------------------------------------------
interface kle_char_if;
  import kle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;
  logic              line_empty;
  logic              overflowed;

  modport source (output valid, output out_char, output last, output line_empty,
                  output overflowed, input ready);
  modport sink   (input valid, input out_char, input last, input line_empty,
                  input overflowed, output ready);

endinterface

### rtl/kle_cell.sv
// ----------------------------------------------------------------------------
// kle_cell
// One position of both stacks: holds a left and a right character and
// shifts them toward or away from the cursor end of the chain.
// ----------------------------------------------------------------------------
module kle_cell
  import kle_pkg::*;
(
  input  logic              clk,
  input  kle_shift_t        shift,
  input  logic [CHAR_W-1:0] left_prev,
  input  logic [CHAR_W-1:0] left_after,
  input  logic [CHAR_W-1:0] right_prev,
  input  logic [CHAR_W-1:0] right_after,
  output logic [CHAR_W-1:0] left_char,
  output logic [CHAR_W-1:0] right_char
);

  always_ff @(posedge clk) begin
    // push: take the neighbor nearer the cursor; pop: take the one farther away
    if (shift.left_push) begin
      left_char <= left_prev;
    end else if (shift.left_pop) begin
      left_char <= left_after;
    end
    if (shift.right_push) begin
      right_char <= right_prev;
    end else if (shift.right_pop) begin
      right_char <= right_after;
    end
  end

endmodule

### rtl/keystroke_line_editor_unit.sv
// ----------------------------------------------------------------------------
// keystroke_line_editor_unit
// Gap-buffer line editor built from a chain of shift cells.
// ----------------------------------------------------------------------------
// Each keys transaction carries one keystroke: insert a character at the
// cursor, backspace, cursor left, cursor right, or end of line. Edit
// keystrokes produce nothing on the line channel and keys.ready stays high.
// An insert into a full line (LINE_DEPTH characters) is dropped and
// remembered, and every result of that line then carries overflowed. End
// of line first walks the cursor to the start of the line, one character
// per cycle, then streams the whole line left to right, one character per
// cycle while the sink keeps line.ready high, marking the last one. An
// empty line yields a single result with line_empty set and out_char zero.
// So an end of line holds off keys while the cursor walks and the line
// streams; both phases move by the single shift step per cycle of the cell
// chain. The output register parts the two channels, so editing of the next
// line may begin while the final character still waits to be taken.
// ----------------------------------------------------------------------------
module keystroke_line_editor_unit
  import kle_pkg::*;
#(
  parameter int LINE_DEPTH = 64
)
(
  input  logic       clk,
  input  logic       rst,
  kle_key_if.sink    keys,
  kle_char_if.source line
);

  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(LINE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNLOAD,
    ST_STREAM
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] left_count, left_count_next;
  logic [CNT_W-1:0] right_count, right_count_next;
  logic             overflow_seen, overflow_seen_next;

  // Output register
  logic              out_valid, out_valid_next;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_empty;
  logic              out_ovf;

  // Load strobe and payload for the output register
  logic              load;
  logic [CHAR_W-1:0] load_char;
  logic              load_last;
  logic              load_empty;

  kle_shift_t        shift;
  logic [CHAR_W-1:0] push_char;
  logic [CNT_W:0]    total;
  logic              out_free;

  // Cell chain: index 0 is the top of both stacks (next to the cursor)
  logic [CHAR_W-1:0] left_q  [LINE_DEPTH];
  logic [CHAR_W-1:0] right_q [LINE_DEPTH];

  assign total    = {1'b0, left_count} + {1'b0, right_count};
  assign out_free = !out_valid || line.ready;

  assign keys.ready      = (state == ST_IDLE);
  assign line.valid      = out_valid;
  assign line.out_char   = out_char;
  assign line.last       = out_last;
  assign line.line_empty = out_empty;
  assign line.overflowed = out_ovf;

  always_comb begin
    state_next         = state;
    left_count_next    = left_count;
    right_count_next   = right_count;
    overflow_seen_next = overflow_seen;
    shift              = '0;
    push_char          = keys.key_char;
    load               = 1'b0;
    load_char          = right_q[0];
    load_last          = 1'b0;
    load_empty         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (keys.valid) begin
          case (keys.cmd)
            CMD_INSERT: begin
              if (total < DEPTH_SUM) begin
                shift.left_push = 1'b1;
                left_count_next = left_count + CNT_ONE;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            CMD_BACKSPACE: begin
              if (left_count != '0) begin
                shift.left_pop  = 1'b1;
                left_count_next = left_count - CNT_ONE;
              end
            end
            CMD_LEFT: begin
              // total never exceeds the depth, so the right stack has room
              if (left_count != '0) begin
                shift.left_pop   = 1'b1;
                shift.right_push = 1'b1;
                left_count_next  = left_count - CNT_ONE;
                right_count_next = right_count + CNT_ONE;
              end
            end
            CMD_RIGHT: begin
              if (right_count != '0) begin
                push_char        = right_q[0];
                shift.right_pop  = 1'b1;
                shift.left_push  = 1'b1;
                right_count_next = right_count - CNT_ONE;
                left_count_next  = left_count + CNT_ONE;
              end
            end
            CMD_EOL: begin
              state_next = (left_count != '0) ? ST_UNLOAD : ST_STREAM;
            end
            default: begin
              // drop unknown commands
            end
          endcase
        end
      end

      ST_UNLOAD: begin
        // Move the cursor to the start of the line
        shift.left_pop   = 1'b1;
        shift.right_push = 1'b1;
        left_count_next  = left_count - CNT_ONE;
        right_count_next = right_count + CNT_ONE;
        if (left_count == CNT_ONE) begin
          state_next = ST_STREAM;
        end
      end

      ST_STREAM: begin
        if (out_free) begin
          load = 1'b1;
          if (right_count == '0) begin
            // empty line: one marker result
            load_char          = '0;
            load_last          = 1'b1;
            load_empty         = 1'b1;
            overflow_seen_next = 1'b0;
            state_next         = ST_IDLE;
          end else begin
            load_last        = (right_count == CNT_ONE);
            shift.right_pop  = 1'b1;
            right_count_next = right_count - CNT_ONE;
            if (right_count == CNT_ONE) begin
              overflow_seen_next = 1'b0;
              state_next         = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (line.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      left_count    <= '0;
      right_count   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      left_count    <= left_count_next;
      right_count   <= right_count_next;
      overflow_seen <= overflow_seen_next;
      out_valid     <= out_valid_next;
    end
    if (load) begin
      out_char  <= load_char;
      out_last  <= load_last;
      out_empty <= load_empty;
      out_ovf   <= overflow_seen;
    end
  end

  // Chain of cells; the far end reloads its own value on a pop
  for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
    logic [CHAR_W-1:0] left_prev, left_after, right_prev, right_after;

    if (i == 0) begin : g_head
      assign left_prev  = push_char;
      assign right_prev = left_q[0];
    end else begin : g_body
      assign left_prev  = left_q[i-1];
      assign right_prev = right_q[i-1];
    end

    if (i == LINE_DEPTH - 1) begin : g_tail
      assign left_after  = left_q[i];
      assign right_after = right_q[i];
    end else begin : g_inner
      assign left_after  = left_q[i+1];
      assign right_after = right_q[i+1];
    end

    kle_cell u_cell (
      .clk         (clk),
      .shift       (shift),
      .left_prev   (left_prev),
      .left_after  (left_after),
      .right_prev  (right_prev),
      .right_after (right_after),
      .left_char   (left_q[i]),
      .right_char  (right_q[i])
    );
  end

`ifndef SYNTHESIS
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    total <= DEPTH_SUM)
    else $error("line length exceeds depth");

  a_unload_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_UNLOAD |-> left_count != '0)
    else $error("cursor walk with empty left stack");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    line.valid && line.line_empty |-> line.last && line.out_char == '0)
    else $error("empty-line result malformed");

  a_eol_holds_keys: assert property (@(posedge clk) disable iff (rst)
    keys.valid && keys.ready && keys.cmd == CMD_EOL |=> !keys.ready)
    else $error("keys accepted during end of line");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load && load_last |=> left_count == '0 && right_count == '0 && !overflow_seen)
    else $error("line state not cleared after last result");
`endif

endmodule

### dv/keystroke_line_editor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_line_editor_checker
// Watches both channels of the line editor, predicts each edited line from
// the accepted keystrokes and compares every character transaction in order.
// ----------------------------------------------------------------------------
module keystroke_line_editor_checker
  import kle_pkg::*;
#(
  parameter int LINE_DEPTH = 64
)
(
  input  logic clk,
  input  logic rst,
  kle_key_if   keys,
  kle_char_if  line,
  output int   errors,
  output int   pending
);

  localparam int IDX_W = $clog2(LINE_DEPTH);

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
    logic              line_empty;
    logic              overflowed;
  } line_beat_t;

  line_beat_t        expected_chars[$];
  logic [CHAR_W-1:0] left_chars  [LINE_DEPTH];
  logic [CHAR_W-1:0] right_chars [LINE_DEPTH];
  int unsigned       left_n;
  int unsigned       right_n;
  logic              overflow_seen;

  function automatic void queue_char(input logic [CHAR_W-1:0] ch, input logic is_last,
                                     input logic empty);
    line_beat_t beat;
    beat.out_char   = ch;
    beat.last       = is_last;
    beat.line_empty = empty;
    beat.overflowed = overflow_seen;
    expected_chars.push_back(beat);
  endfunction

  // Gap buffer: left stack grows at the cursor, right stack holds the tail
  // with the character just right of the cursor on top.
  function automatic void apply_keystroke(input logic [CMD_W-1:0] code,
                                          input logic [CHAR_W-1:0] ch);
    int unsigned total;
    int unsigned produced;
    total    = left_n + right_n;
    produced = 0;
    case (code)
      CMD_INSERT: begin
        if (total < LINE_DEPTH && left_n < LINE_DEPTH) begin
          left_chars[IDX_W'(left_n)] = ch;
          left_n++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      CMD_BACKSPACE: begin
        if (left_n > 0) left_n--;
      end
      CMD_LEFT: begin
        if (left_n > 0 && right_n < LINE_DEPTH) begin
          left_n--;
          right_chars[IDX_W'(right_n)] = left_chars[IDX_W'(left_n)];
          right_n++;
        end
      end
      CMD_RIGHT: begin
        if (right_n > 0 && left_n < LINE_DEPTH) begin
          right_n--;
          left_chars[IDX_W'(left_n)] = right_chars[IDX_W'(right_n)];
          left_n++;
        end
      end
      CMD_EOL: begin
        if (total == 0) begin
          queue_char('0, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < left_n; i++) begin
            produced++;
            queue_char(left_chars[IDX_W'(i)], produced == total, 1'b0);
          end
          for (int i = right_n; i > 0; i--) begin
            produced++;
            queue_char(right_chars[IDX_W'(i - 1)], produced == total, 1'b0);
          end
        end
        left_n        = 0;
        right_n       = 0;
        overflow_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    line_beat_t want;
    if (rst) begin
      expected_chars.delete();
      left_n        = 0;
      right_n       = 0;
      overflow_seen = 1'b0;
    end else begin
      if (keys.valid === 1'b1 && keys.ready === 1'b1) begin
        apply_keystroke(keys.cmd, keys.key_char);
      end
      if (line.valid === 1'b1 && line.ready === 1'b1) begin
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected line transaction: expected none, %s",
                   $time, "got:");
          $display("  char %02h last %b empty %b ovf %b",
                   line.out_char, line.last, line.line_empty, line.overflowed);
        end else begin
          want = expected_chars.pop_front();
          if (line.out_char !== want.out_char || line.last !== want.last ||
              line.line_empty !== want.line_empty || line.overflowed !== want.overflowed) begin
            errors++;
            $display("%0t: line mismatch: expected char %02h last %b empty %b ovf %b,",
                     $time, want.out_char, want.last, want.line_empty, want.overflowed);
            $display("  got char %02h last %b empty %b ovf %b",
                     line.out_char, line.last, line.line_empty, line.overflowed);
          end
        end
      end
    end
    pending <= expected_chars.size();
  end

endmodule

### dv/keystroke_line_editor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_line_editor_unit_tb
// Drives keystroke lines into the gap-buffer line editor with random idling
// on both channels; a checker beside the block predicts and compares every
// streamed character, and this module gives the verdict.
// ----------------------------------------------------------------------------
module keystroke_line_editor_unit_tb;
  import kle_pkg::*;

  localparam int LINE_DEPTH   = 64;
  localparam int ITEM_TARGET  = 300;
  // An end of line may walk the cursor and stream up to LINE_DEPTH characters,
  // each one possibly stalled by the sink; allow that before the verdict.
  localparam int DRAIN_CYCLES = 6 * LINE_DEPTH + 16;
  localparam longint TIMEOUT_NS = 64'd4_000_000;

  localparam logic [CHAR_W-1:0] CH_DASH  = "-";
  localparam logic [CHAR_W-1:0] CH_LT    = "<";
  localparam logic [CHAR_W-1:0] CH_GT    = ">";
  // Codes past end of line; the block must ignore them.
  localparam logic [CMD_W-1:0]  CMD_BAD5 = 3'd5;
  localparam logic [CMD_W-1:0]  CMD_BAD6 = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  bit   no_stall = 1'b0;
  int   key_count = 0;

  kle_key_if  keys ();
  kle_char_if line ();

  keystroke_line_editor_unit #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk  (clk),
    .rst  (rst),
    .keys (keys),
    .line (line)
  );

  keystroke_line_editor_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .keys    (keys),
    .line    (line),
    .errors  (errors),
    .pending (pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs on either channel.
  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one keystroke: idle a random number of cycles first, then hold it
  // until the block takes it. Return at the accepting edge with valid still
  // high, so a back-to-back transaction follows without a bubble.
  task automatic send_key(input logic [CMD_W-1:0] code, input logic [CHAR_W-1:0] ch);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      keys.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    keys.valid    <= 1'b1;
    keys.cmd      <= code;
    keys.key_char <= ch;
    do @(posedge clk); while (keys.ready !== 1'b1);
    // Ignored codes do not count toward the stimulus length.
    if (code <= CMD_EOL) key_count++;
  endtask

  // Hold the sender until every predicted character has been taken.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sink side: stall a random number of cycles before each transaction, then
  // keep ready high until a character is taken.
  initial begin : line_sink
    int gap;
    line.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        line.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      line.ready <= 1'b1;
      do @(posedge clk); while (line.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int  line_no;
    int  len;
    int  fill;
    int  roll;
    bit  full_line;

    keys.valid    <= 1'b0;
    keys.cmd      <= CMD_INSERT;
    keys.key_char <= '0;

    // Synchronous reset, then release
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- Directed part ----------------------------------------------------
    // Nothing to delete or move on an empty line, then an empty end of line.
    send_key(CMD_BACKSPACE, 8'h00);
    send_key(CMD_LEFT,      8'hFF);
    send_key(CMD_RIGHT,     8'h00);
    send_key(CMD_EOL,       8'hFF);

    // Extreme bytes, cursor moves in both directions, a right move past the
    // end of the line, an insert in the middle and a backspace at the end.
    send_key(CMD_INSERT,    8'h00);
    send_key(CMD_INSERT,    8'hFF);
    send_key(CMD_INSERT,    8'h61);
    send_key(CMD_LEFT,      8'h00);
    send_key(CMD_LEFT,      8'h00);
    send_key(CMD_INSERT,    CH_LT);
    send_key(CMD_BAD5,      8'hAA);
    send_key(CMD_RIGHT,     8'h55);
    send_key(CMD_RIGHT,     8'h00);
    send_key(CMD_RIGHT,     8'h00);
    send_key(CMD_BAD6,      8'h55);
    send_key(CMD_BACKSPACE, 8'h00);
    send_key(CMD_LEFT,      8'h00);
    send_key(CMD_INSERT,    CH_DASH);
    send_key(CMD_BAD7,      8'hFF);
    send_key(CMD_EOL,       8'h00);

    // Line edited back down to nothing, with a backspace at the start.
    send_key(CMD_INSERT,    CH_GT);
    send_key(CMD_BACKSPACE, 8'h00);
    send_key(CMD_BACKSPACE, 8'h00);
    send_key(CMD_EOL,       8'h00);

    // Let the directed lines fully drain before random traffic.
    keys.valid <= 1'b0;
    wait_drained();

    // --- Random part ------------------------------------------------------
    // Mostly well-formed lines of random edits closed by an end of line;
    // a few noise keystrokes with any code, and two lines that overrun the
    // buffer so that the overflow flag is exercised.
    line_no = 0;
    while (key_count < ITEM_TARGET) begin
      // Every sixth line runs with no idling on either side.
      no_stall  = (line_no % 6 == 5);
      full_line = (line_no == 2 || line_no == 9);
      if (full_line) begin
        fill = LINE_DEPTH + $urandom_range(1, 6);
        for (int k = 0; k < fill; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_key($urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT,
                     CHAR_W'($urandom_range(0, 255)));
          end
          send_key(CMD_INSERT, CHAR_W'($urandom_range(0, 255)));
        end
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (int k = 0; k < len; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            send_key(CMD_W'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)));
          end else if (roll < 55) begin
            send_key(CMD_INSERT, CHAR_W'($urandom_range(0, 255)));
          end else if (roll < 70) begin
            send_key(CMD_BACKSPACE, CHAR_W'($urandom_range(0, 255)));
          end else if (roll < 85) begin
            send_key(CMD_LEFT, CHAR_W'($urandom_range(0, 255)));
          end else begin
            send_key(CMD_RIGHT, CHAR_W'($urandom_range(0, 255)));
          end
        end
      end
      send_key(CMD_EOL, CHAR_W'($urandom_range(0, 255)));
      // After an overrun line, drop valid and wait out the whole stream.
      if (full_line) begin
        keys.valid <= 1'b0;
        wait_drained();
      end
      line_no++;
    end

    // --- End of run -------------------------------------------------------
    keys.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) begin
      $display("%0t: %0d predicted line transactions never arrived", $time, pending);
    end
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
